@@ rtl/core/qrm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrm_pkg: quaternion to rotation matrix shared definitions
// Widths, stage counts and pipeline payload types used by every stage.
// ----------------------------------------------------------------------------
package qrm_pkg;

	localparam int COMP_WIDTH_DEF = 16;
	localparam int RED_W          = 17;
	localparam int PROD_W         = 34;
	localparam int SUM_W          = 36;
	localparam int MAG_W          = 34;
	localparam int NUM_W          = 50;
	localparam int DEN_W          = 35;
	localparam int Q_W            = 15;
	localparam int ENT_W          = 16;
	localparam int N_ENT          = 9;
	localparam int FRAC_SH        = 15;
	localparam int ONE_Q14        = 16384;
	localparam int PREP_ST        = 2;
	localparam int PROD_ST        = 3;
	localparam int DIV_ST         = Q_W;
	localparam int NUM_ST         = PREP_ST + PROD_ST + DIV_ST + 1;

	typedef struct packed {
		logic signed [RED_W-1:0] x;
		logic signed [RED_W-1:0] y;
		logic signed [RED_W-1:0] z;
		logic signed [RED_W-1:0] w;
		logic                    degen;
	} quat_t;

	typedef struct packed {
		logic [NUM_W-1:0] rem;
		logic [Q_W-1:0]   quo;
		logic             neg;
	} lane_t;

	typedef struct packed {
		lane_t [N_ENT-1:0] lane;
		logic [DEN_W-1:0]  den;
		logic              degen;
	} div_t;

endpackage

@@ rtl/core/qrm_prep.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrm_prep: component conditioning
// Sign-extends the components and scales them down to 16 magnitude bits.
// ----------------------------------------------------------------------------
module qrm_prep #(
	parameter int COMPONENT_WIDTH = qrm_pkg::COMP_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic [qrm_pkg::PREP_ST-1:0]         adv,
	input  logic [3:0][COMPONENT_WIDTH-1:0]     comp,
	output qrm_pkg::quat_t                      quat_s2
);

	localparam int SHW = $clog2(COMPONENT_WIDTH + 1);

	logic [3:0][COMPONENT_WIDTH-1:0] mag;
	logic [3:0]                      neg;
	logic [COMPONENT_WIDTH-1:0]      all_bits;
	logic [SHW-1:0]                  len;
	logic [SHW-1:0]                  sh;

	logic [3:0][COMPONENT_WIDTH-1:0] mag_s1;
	logic [3:0]                      neg_s1;
	logic [SHW-1:0]                  sh_s1;
	logic                            degen_s1;

	logic [3:0][qrm_pkg::RED_W-1:0]  red;

	always_comb begin
		all_bits = '0;
		for (int i = 0; i < 4; i++) begin
			neg[i] = comp[i][COMPONENT_WIDTH-1];
			mag[i] = neg[i] ? COMPONENT_WIDTH'(-comp[i]) : comp[i];
			all_bits = all_bits | mag[i];
		end
		len = '0;
		for (int b = 0; b < COMPONENT_WIDTH; b++) begin
			if (all_bits[b])
				len = SHW'(b + 1);
		end
		sh = (int'(len) > 16) ? SHW'(int'(len) - 16) : '0;
	end

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			mag_s1   <= mag;
			neg_s1   <= neg;
			sh_s1    <= sh;
			degen_s1 <= (all_bits == '0);
		end
	end

	always_comb begin
		logic [COMPONENT_WIDTH+15:0] ext;
		logic [qrm_pkg::RED_W-1:0]   t;
		for (int i = 0; i < 4; i++) begin
			ext = {16'd0, mag_s1[i]} >> sh_s1;
			t = {1'b0, ext[15:0]};
			red[i] = neg_s1[i] ? qrm_pkg::RED_W'(-t) : t;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			quat_s2.x     <= signed'(red[0]);
			quat_s2.y     <= signed'(red[1]);
			quat_s2.z     <= signed'(red[2]);
			quat_s2.w     <= signed'(red[3]);
			quat_s2.degen <= degen_s1;
		end
	end

endmodule

@@ rtl/core/qrm_prod.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrm_prod: products and numerators
// Forms the ten component products, the squared norm and nine numerators,
// then sets up the dividend and divisor of each entry.
// ----------------------------------------------------------------------------
module qrm_prod (
	input  logic                        clk,
	input  logic [qrm_pkg::PROD_ST-1:0] adv,
	input  qrm_pkg::quat_t              quat_s2,
	output qrm_pkg::div_t               div_s5
);

	typedef logic signed [qrm_pkg::PROD_W-1:0] prod_t;
	typedef logic signed [qrm_pkg::SUM_W-1:0]  sum_t;

	prod_t xx_s3, yy_s3, zz_s3, ww_s3, xy_s3, xz_s3, yz_s3, wx_s3, wy_s3, wz_s3;
	logic  degen_s3;

	sum_t                      num_s4 [qrm_pkg::N_ENT];
	logic [qrm_pkg::MAG_W-1:0] n_s4;
	logic                      degen_s4;

	sum_t                      xx, yy, zz, ww, xy, xz, yz, wx, wy, wz, n_full;
	qrm_pkg::div_t             setup;

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			xx_s3    <= quat_s2.x * quat_s2.x;
			yy_s3    <= quat_s2.y * quat_s2.y;
			zz_s3    <= quat_s2.z * quat_s2.z;
			ww_s3    <= quat_s2.w * quat_s2.w;
			xy_s3    <= quat_s2.x * quat_s2.y;
			xz_s3    <= quat_s2.x * quat_s2.z;
			yz_s3    <= quat_s2.y * quat_s2.z;
			wx_s3    <= quat_s2.w * quat_s2.x;
			wy_s3    <= quat_s2.w * quat_s2.y;
			wz_s3    <= quat_s2.w * quat_s2.z;
			degen_s3 <= quat_s2.degen;
		end
	end

	always_comb begin
		xx = qrm_pkg::SUM_W'(xx_s3);
		yy = qrm_pkg::SUM_W'(yy_s3);
		zz = qrm_pkg::SUM_W'(zz_s3);
		ww = qrm_pkg::SUM_W'(ww_s3);
		xy = qrm_pkg::SUM_W'(xy_s3);
		xz = qrm_pkg::SUM_W'(xz_s3);
		yz = qrm_pkg::SUM_W'(yz_s3);
		wx = qrm_pkg::SUM_W'(wx_s3);
		wy = qrm_pkg::SUM_W'(wy_s3);
		wz = qrm_pkg::SUM_W'(wz_s3);
		n_full = xx + yy + zz + ww;
	end

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			num_s4[0] <= xx + ww - yy - zz;
			num_s4[1] <= (xy - wz) <<< 1;
			num_s4[2] <= (xz + wy) <<< 1;
			num_s4[3] <= (xy + wz) <<< 1;
			num_s4[4] <= yy + ww - xx - zz;
			num_s4[5] <= (yz - wx) <<< 1;
			num_s4[6] <= (xz - wy) <<< 1;
			num_s4[7] <= (yz + wx) <<< 1;
			num_s4[8] <= zz + ww - xx - yy;
			n_s4      <= qrm_pkg::MAG_W'(n_full);
			degen_s4  <= degen_s3;
		end
	end

	always_comb begin
		logic [qrm_pkg::SUM_W-1:0] a;
		setup.den   = {1'b0, n_s4} << 1;
		setup.degen = degen_s4;
		for (int i = 0; i < qrm_pkg::N_ENT; i++) begin
			a = num_s4[i][qrm_pkg::SUM_W-1] ? qrm_pkg::SUM_W'(-num_s4[i])
			                                 : qrm_pkg::SUM_W'(num_s4[i]);
			setup.lane[i].neg = num_s4[i][qrm_pkg::SUM_W-1];
			setup.lane[i].quo = '0;
			setup.lane[i].rem = (qrm_pkg::NUM_W'(a[qrm_pkg::MAG_W-1:0]) << qrm_pkg::FRAC_SH)
			                    + qrm_pkg::NUM_W'(n_s4);
		end
	end

	always_ff @(posedge clk) begin
		if (adv[2])
			div_s5 <= setup;
	end

endmodule

@@ rtl/core/qrm_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrm_div: pipelined restoring divider
// Nine lanes share one divisor; each stage settles one quotient bit.
// ----------------------------------------------------------------------------
module qrm_div (
	input  logic                       clk,
	input  logic [qrm_pkg::DIV_ST-1:0] adv,
	input  qrm_pkg::div_t              div_in,
	output qrm_pkg::div_t              div_out
);

	qrm_pkg::div_t st_q [qrm_pkg::DIV_ST];

	for (genvar k = 0; k < qrm_pkg::DIV_ST; k++) begin : g_stage
		localparam int BIT = qrm_pkg::Q_W - 1 - k;

		qrm_pkg::div_t prev;
		qrm_pkg::div_t next;

		if (k == 0) begin : g_first
			assign prev = div_in;
		end else begin : g_rest
			assign prev = st_q[k-1];
		end

		always_comb begin
			logic [qrm_pkg::NUM_W-1:0] sd;
			logic [qrm_pkg::NUM_W:0]   diff;
			next = prev;
			sd = qrm_pkg::NUM_W'(prev.den) << BIT;
			for (int i = 0; i < qrm_pkg::N_ENT; i++) begin
				diff = {1'b0, prev.lane[i].rem} - {1'b0, sd};
				if (!diff[qrm_pkg::NUM_W]) begin
					next.lane[i].rem      = diff[qrm_pkg::NUM_W-1:0];
					next.lane[i].quo[BIT] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk) begin
			if (adv[k])
				st_q[k] <= next;
		end
	end

	assign div_out = st_q[qrm_pkg::DIV_ST-1];

endmodule

@@ rtl/core/quaternion_to_rotation_matrix_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_to_rotation_matrix_unit: quaternion to 3x3 rotation matrix
// Scales by 2 / squared norm, rounds each entry to Q2.14; zero input gives
// the identity with the degenerate flag.
//
// channel  dir  tdata (low bit up)                      tuser
// s_       in   quat_x, quat_y, quat_z, quat_w          -
// m_       out  r0c0 r0c1 r0c2 r1c0 r1c1 r1c2 r2c0      degenerate
//               r2c1 r2c2 (16 bits each)
//
// One beat per cycle sustained while m_tready stays high; the 15-stage
// divider sits behind two conditioning and three product stages.
// Reset clears only the stage valid bits.
// Each stage advances when it is empty or the next one advances, so a
// stall on m_tready fills bubbles before s_tready drops.
// ----------------------------------------------------------------------------
module quaternion_to_rotation_matrix_unit #(
	parameter int COMPONENT_WIDTH = qrm_pkg::COMP_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// quat_x, quat_y, quat_z, quat_w
	input  logic [((4*COMPONENT_WIDTH+7)/8)*8-1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// r0c0, r0c1, r0c2, r1c0, r1c1, r1c2, r2c0, r2c1, r2c2
	output logic [qrm_pkg::N_ENT*qrm_pkg::ENT_W-1:0] m_tdata,
	// degenerate
	output logic m_tuser
);

	localparam int NS    = qrm_pkg::NUM_ST;
	localparam int P0    = 1;
	localparam int R0    = P0 + qrm_pkg::PREP_ST;
	localparam int D0    = R0 + qrm_pkg::PROD_ST;

	logic [NS:1]                       vld_q;
	logic [NS:1]                       adv;
	logic [3:0][COMPONENT_WIDTH-1:0]   comp;
	qrm_pkg::quat_t                    quat_s2;
	qrm_pkg::div_t                     div_s5;
	qrm_pkg::div_t                     div_s20;

	logic [qrm_pkg::N_ENT-1:0][qrm_pkg::ENT_W-1:0] ent;
	logic [qrm_pkg::N_ENT-1:0][qrm_pkg::ENT_W-1:0] ent_s21;
	logic                                          degen_s21;

	always_comb begin
		adv[NS] = !vld_q[NS] || m_tready;
		for (int k = NS - 1; k >= 1; k--)
			adv[k] = !vld_q[k] || adv[k+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[1])
				vld_q[1] <= s_tvalid;
			for (int k = 2; k <= NS; k++) begin
				if (adv[k])
					vld_q[k] <= vld_q[k-1];
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 4; i++)
			comp[i] = s_tdata[i*COMPONENT_WIDTH +: COMPONENT_WIDTH];
	end

	qrm_prep #(
		.COMPONENT_WIDTH(COMPONENT_WIDTH)
	) u_prep (
		.clk    (clk),
		.adv    (adv[R0-1:P0]),
		.comp   (comp),
		.quat_s2(quat_s2)
	);

	qrm_prod u_prod (
		.clk    (clk),
		.adv    (adv[D0-1:R0]),
		.quat_s2(quat_s2),
		.div_s5 (div_s5)
	);

	qrm_div u_div (
		.clk    (clk),
		.adv    (adv[NS-1:D0]),
		.div_in (div_s5),
		.div_out(div_s20)
	);

	always_comb begin
		logic [qrm_pkg::Q_W-1:0]   q;
		logic [qrm_pkg::ENT_W-1:0] mq;
		for (int i = 0; i < qrm_pkg::N_ENT; i++) begin
			q = div_s20.lane[i].quo;
			if (q > qrm_pkg::Q_W'(qrm_pkg::ONE_Q14))
				q = qrm_pkg::Q_W'(qrm_pkg::ONE_Q14);
			mq = {1'b0, q};
			if (div_s20.degen)
				ent[i] = (i % 4 == 0) ? qrm_pkg::ENT_W'(qrm_pkg::ONE_Q14) : '0;
			else
				ent[i] = div_s20.lane[i].neg ? qrm_pkg::ENT_W'(-mq) : mq;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[NS]) begin
			ent_s21   <= ent;
			degen_s21 <= div_s20.degen;
		end
	end

	assign s_tready = adv[1];
	assign m_tvalid = vld_q[NS];
	assign m_tdata  = ent_s21;
	assign m_tuser  = degen_s21;

`ifndef SYNTH
	a_ready_low_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (m_tvalid && !m_tready && (&vld_q)))
		else $error("input stalled while pipeline has room");

	a_degen_identity: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata[15:0] == 16'(qrm_pkg::ONE_Q14)
			&& m_tdata[31:16] == '0 && m_tdata[143:128] == 16'(qrm_pkg::ONE_Q14)))
		else $error("degenerate beat is not identity");

	a_entry_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[15:0]) <= $signed(16'(qrm_pkg::ONE_Q14))
			&& $signed(m_tdata[15:0]) >= -$signed(16'(qrm_pkg::ONE_Q14))))
		else $error("diagonal entry out of range");
`endif

endmodule

@@ sim/quaternion_to_rotation_matrix_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_to_rotation_matrix_unit_tb: self-checking stream testbench
// Drives quaternions into the slave side and compares each matrix beat with
// an integer predictor (exact ratio, round half away from zero, Q2.14) or a
// stored matrix. A directed table covers zero, extremes, axis cases; random
// quaternions follow in three idle patterns and one long output hold-off.
// ----------------------------------------------------------------------------
module quaternion_to_rotation_matrix_unit_tb;

	localparam int CW = 16;
	localparam int LIMIT = 400000;
	localparam int N_RAND = 1350;
	localparam int N_ENT = qrm_pkg::N_ENT;
	localparam int ENT_W = qrm_pkg::ENT_W;
	localparam int ONE_Q14 = qrm_pkg::ONE_Q14;

	typedef struct packed {
		logic [N_ENT*ENT_W-1:0] ent;
		logic                   degen;
	} mat_t;

	typedef struct {
		logic [4*CW-1:0] q;
		bit              has_exp;
		mat_t            exp;
	} row_t;

	logic clk, arst_n;
	logic s_tvalid, s_tready, m_tvalid, m_tready, m_tuser;
	logic [4*CW-1:0] s_tdata;
	logic [N_ENT*ENT_W-1:0] m_tdata;

	mat_t matrix_q[$];
	int   mismatches;
	int   cycles;
	int   src_idle, snk_idle;
	bit   hold_off;
	bit   done_driving;

	quaternion_to_rotation_matrix_unit #(.COMPONENT_WIDTH(CW)) dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic longint ratio14(longint num, longint den);
		longint a, q;
		a = num < 0 ? -num : num;
		q = ((a <<< 15) + den) / (den <<< 1);
		if (q > ONE_Q14) q = ONE_Q14;
		return num < 0 ? -q : q;
	endfunction

	function automatic mat_t rotation_of(logic [4*CW-1:0] qd);
		longint c[4];
		longint x, y, z, w, n;
		longint r[9];
		mat_t m;
		for (int i = 0; i < 4; i++) c[i] = longint'($signed(qd[i*CW +: CW]));
		m = '0;
		if (c[0] == 0 && c[1] == 0 && c[2] == 0 && c[3] == 0) begin
			m.ent[0*ENT_W +: ENT_W] = ENT_W'(ONE_Q14);
			m.ent[4*ENT_W +: ENT_W] = ENT_W'(ONE_Q14);
			m.ent[8*ENT_W +: ENT_W] = ENT_W'(ONE_Q14);
			m.degen = 1'b1;
			return m;
		end
		x = c[0]; y = c[1]; z = c[2]; w = c[3];
		n = x*x + y*y + z*z + w*w;
		r[0] = ratio14(n - 2*(y*y + z*z), n);
		r[1] = ratio14(2*(x*y - w*z), n);
		r[2] = ratio14(2*(x*z + w*y), n);
		r[3] = ratio14(2*(x*y + w*z), n);
		r[4] = ratio14(n - 2*(x*x + z*z), n);
		r[5] = ratio14(2*(y*z - w*x), n);
		r[6] = ratio14(2*(x*z - w*y), n);
		r[7] = ratio14(2*(y*z + w*x), n);
		r[8] = ratio14(n - 2*(x*x + y*y), n);
		for (int i = 0; i < 9; i++) m.ent[i*ENT_W +: ENT_W] = r[i][ENT_W-1:0];
		return m;
	endfunction

	function automatic logic [4*CW-1:0] pack_q(int x, int y, int z, int w);
		return {w[CW-1:0], z[CW-1:0], y[CW-1:0], x[CW-1:0]};
	endfunction

	function automatic logic [CW-1:0] rand_comp();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return CW'($urandom_range(0, 15) - 8);
			3: return CW'($urandom_range(0, 255) - 128);
			default: return CW'($urandom);
		endcase
	endfunction

	// identity-looking rows are read straight off the definition
	function automatic mat_t ident(int sx, int sy, int sz);
		mat_t m;
		m = '0;
		m.ent[0*ENT_W +: ENT_W] = ENT_W'(sx);
		m.ent[4*ENT_W +: ENT_W] = ENT_W'(sy);
		m.ent[8*ENT_W +: ENT_W] = ENT_W'(sz);
		return m;
	endfunction

	task automatic send_quat(logic [4*CW-1:0] qd, mat_t expv);
		while (src_idle > 0 && $urandom_range(0, 99) < src_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= qd;
		matrix_q.push_back(expv);
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	initial begin
		row_t tbl[$];
		row_t rw;
		mat_t m;
		s_tvalid = 1'b0;
		s_tdata = '0;
		src_idle = 0;
		snk_idle = 0;
		hold_off = 1'b0;
		done_driving = 1'b0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		m = ident(ONE_Q14, ONE_Q14, ONE_Q14); m.degen = 1'b1;
		tbl.push_back('{pack_q(0, 0, 0, 0), 1, m});
		tbl.push_back('{pack_q(0, 0, 0, 32767), 1, ident(ONE_Q14, ONE_Q14, ONE_Q14)});
		tbl.push_back('{pack_q(0, 0, 0, -32768), 1, ident(ONE_Q14, ONE_Q14, ONE_Q14)});
		tbl.push_back('{pack_q(1, 0, 0, 0), 1, ident(ONE_Q14, -ONE_Q14, -ONE_Q14)});
		tbl.push_back('{pack_q(0, -32768, 0, 0), 1, ident(-ONE_Q14, ONE_Q14, -ONE_Q14)});
		tbl.push_back('{pack_q(0, 0, 32767, 0), 1, ident(-ONE_Q14, -ONE_Q14, ONE_Q14)});
		tbl.push_back('{pack_q(0, 0, 0, 1), 1, ident(ONE_Q14, ONE_Q14, ONE_Q14)});
		tbl.push_back('{pack_q(-32768, -32768, -32768, -32768), 0, '0});
		tbl.push_back('{pack_q(32767, 32767, 32767, 32767), 0, '0});
		tbl.push_back('{pack_q(32767, -32768, 32767, -32768), 0, '0});
		tbl.push_back('{pack_q(-1, -1, -1, -1), 0, '0});
		tbl.push_back('{pack_q(1, 1, 0, 0), 0, '0});
		tbl.push_back('{pack_q(0, 0, 23170, 23170), 0, '0});
		tbl.push_back('{pack_q(23170, 0, 0, -23170), 0, '0});
		tbl.push_back('{pack_q(1, 2, 3, 4), 0, '0});
		tbl.push_back('{pack_q(-32768, 1, -1, 32767), 0, '0});
		tbl.push_back('{pack_q(21845, -21846, 3, 0), 0, '0});
		tbl.push_back('{pack_q(16'h5555, 16'haaaa, 16'h5555, 16'haaaa), 0, '0});
		foreach (tbl[i]) begin
			rw = tbl[i];
			send_quat(rw.q, rw.has_exp ? rw.exp : rotation_of(rw.q));
		end

		for (int i = 0; i < N_RAND; i++) begin
			logic [4*CW-1:0] qd;
			if (i == N_RAND/3) begin
				src_idle = 61; snk_idle = 37;
			end else if (i == 2*N_RAND/3) begin
				src_idle = 0; snk_idle = 0;
				hold_off = 1'b1;
			end else if (i == 0) begin
				src_idle = 37; snk_idle = 61;
			end
			qd = {rand_comp(), rand_comp(), rand_comp(), rand_comp()};
			send_quat(qd, rotation_of(qd));
		end
		s_tvalid <= 1'b0;
		done_driving = 1'b1;
	end

	// output side: random stalls plus one long hold-off counted here
	initial begin
		int hold_cnt;
		m_tready = 1'b0;
		hold_cnt = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off && hold_cnt < 200) begin
				hold_cnt++;
				m_tready <= 1'b0;
			end else
				m_tready <= ($urandom_range(0, 99) >= snk_idle);
		end
	end

	always @(posedge clk) begin
		mat_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tdata, m_tuser};
			if (matrix_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected beat %h", got);
			end else begin
				want = matrix_q.pop_front();
				for (int i = 0; i < N_ENT; i++)
					if (got.ent[i*ENT_W +: ENT_W] !== want.ent[i*ENT_W +: ENT_W]) begin
						mismatches++;
						if (mismatches <= 10)
							$display("entry %0d: expected %0d, got %0d", i,
								$signed(want.ent[i*ENT_W +: ENT_W]),
								$signed(got.ent[i*ENT_W +: ENT_W]));
					end
				if (got.degen !== want.degen) begin
					mismatches++;
					if (mismatches <= 10)
						$display("degenerate: expected %b, got %b", want.degen, got.degen);
				end
			end
		end
	end

	initial begin
		mismatches = 0;
		cycles = 0;
		@(posedge arst_n);
		while (!(done_driving && matrix_q.size() == 0) && cycles < LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		if (cycles >= LIMIT) begin
			$display("quaternion_to_rotation_matrix_unit_tb failed");
			$finish;
		end
		repeat (40) @(posedge clk);
		if (mismatches == 0 && matrix_q.size() == 0)
			$display("quaternion_to_rotation_matrix_unit_tb passed");
		else
			$display("quaternion_to_rotation_matrix_unit_tb failed");
		$finish;
	end

endmodule

@@ quaternion_to_rotation_matrix_unit.f @@
rtl/core/qrm_pkg.sv
rtl/core/qrm_prep.sv
rtl/core/qrm_prod.sv
rtl/core/qrm_div.sv
rtl/core/quaternion_to_rotation_matrix_unit.sv
sim/quaternion_to_rotation_matrix_unit_tb.sv
